FILE: hw/rtl/lrq_pkg.sv
package lrq_pkg;

	// Sizes
	localparam int LRQ_MAX_ELEMENTS = 512;
	localparam int LRQ_DATA_W       = 32;
	localparam int LRQ_CMD_W        = 3;
	localparam int LRQ_BASIS_W      = 10;
	localparam int LRQ_TGT_W        = LRQ_BASIS_W - 1;
	localparam int LRQ_STATUS_W     = 2;

	// Command codes
	localparam logic [LRQ_CMD_W-1:0] CMD_APPEND    = 3'd0;
	localparam logic [LRQ_CMD_W-1:0] CMD_MAX_BELOW = 3'd1;
	localparam logic [LRQ_CMD_W-1:0] CMD_DISTANCE  = 3'd2;
	localparam logic [LRQ_CMD_W-1:0] CMD_COUNT     = 3'd3;
	localparam logic [LRQ_CMD_W-1:0] CMD_MEDIAN    = 3'd4;
	localparam logic [LRQ_CMD_W-1:0] CMD_CLEAR     = 3'd5;

	// Status codes
	localparam logic [LRQ_STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [LRQ_STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [LRQ_STATUS_W-1:0] ST_FULL  = 2'd2;

	// Query token walking down the row of cells
	typedef struct packed {
		logic                         vld;
		logic                         anyb;
		logic signed [LRQ_DATA_W-1:0] maxb;
		logic signed [LRQ_DATA_W-1:0] minv;
		logic                         hit;
		logic signed [LRQ_DATA_W-1:0] pick;
	} lrq_tok_t;

	// Element copy moving along one of the two rank lines
	typedef struct packed {
		logic                         vld;
		logic signed [LRQ_DATA_W-1:0] val;
	} lrq_line_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                         wr_en;
		logic                         load;
		logic                         rank_en;
		logic                         med;
		logic signed [LRQ_DATA_W-1:0] wr_val;
		logic signed [LRQ_DATA_W-1:0] key;
	} lrq_ctl_t;

endpackage

FILE: hw/rtl/lrq_cmd_if.sv
interface lrq_cmd_if import lrq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [LRQ_CMD_W-1:0]          command;
	logic signed [LRQ_DATA_W-1:0]  value;
	logic [LRQ_BASIS_W-1:0]        rank_basis;

	modport source (output valid, command, value, rank_basis, input ready);
	modport sink (input valid, command, value, rank_basis, output ready);
endinterface

FILE: hw/rtl/lrq_rsp_if.sv
interface lrq_rsp_if import lrq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [LRQ_DATA_W-1:0]  answer;
	logic [LRQ_STATUS_W-1:0]       status;

	modport source (output valid, answer, status, input ready);
	modport sink (input valid, answer, status, output ready);
endinterface

FILE: hw/rtl/lrq_cell.sv
module lrq_cell import lrq_pkg::*; #(
	parameter int MAX_ELEMENTS = LRQ_MAX_ELEMENTS,
	parameter int IDX          = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lrq_ctl_t                             ctl,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    count,
	input  logic [LRQ_TGT_W-1:0]                 target,
	input  lrq_tok_t                             tok_i,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    cnt_i,
	output lrq_tok_t                             tok_o,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]    cnt_o,
	input  lrq_line_t                            rl_i,
	output lrq_line_t                            rl_o,
	input  lrq_line_t                            ll_i,
	output lrq_line_t                            ll_o
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int RW = $clog2(MAX_ELEMENTS);
	localparam int TW = (RW > LRQ_TGT_W) ? RW : LRQ_TGT_W;
	localparam logic [CW-1:0] IDX_C    = CW'(IDX);
	localparam logic [CW-1:0] IDX_NEXT = CW'(IDX + 1);

	logic signed [LRQ_DATA_W-1:0] elem_q;
	lrq_line_t                    rl_q;
	lrq_line_t                    ll_q;
	logic [RW-1:0]                rank_q;
	lrq_tok_t                     tok_q;
	logic [CW-1:0]                cnt_q;

	logic     act;
	logic     last;
	logic     lt;
	logic     rk_match;
	logic     hit_now;
	lrq_tok_t tok_d;
	logic [CW-1:0] cnt_d;
	logic [RW-1:0] rank_inc;

	// Store the appended value when this cell is the next free slot
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (IDX_C == count)) begin
			elem_q <= ctl.wr_val;
		end
	end

	// Rank lines: load own element, then shift right and left each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q <= '0;
			ll_q <= '0;
		end else if (ctl.load) begin
			rl_q.vld <= act;
			rl_q.val <= elem_q;
			ll_q.vld <= act;
			ll_q.val <= elem_q;
		end else begin
			rl_q <= rl_i;
			ll_q <= ll_i;
		end
	end

	// Count the passing elements that are strictly smaller than this one
	always_comb begin
		rank_inc = RW'(rl_q.vld && (rl_q.val < elem_q)) +
			RW'(ll_q.vld && (ll_q.val < elem_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rank_q <= '0;
		end else if (ctl.rank_en) begin
			rank_q <= rank_q + rank_inc;
		end
	end

	// Fold this element into the passing query token
	always_comb begin
		act      = IDX_C < count;
		last     = IDX_NEXT == count;
		lt       = elem_q < ctl.key;
		rk_match = TW'(rank_q) == TW'(target);
		hit_now  = ctl.med ? (rk_match || last) : ((elem_q == ctl.key) || last);
		tok_d    = tok_i;
		cnt_d    = cnt_i;
		if (act) begin
			cnt_d = cnt_i + CW'(lt);
			if (lt) begin
				tok_d.anyb = 1'b1;
				if (!tok_i.anyb || (tok_i.maxb < elem_q)) begin
					tok_d.maxb = elem_q;
				end
			end
			if ((IDX == 0) || (elem_q < tok_i.minv)) begin
				tok_d.minv = elem_q;
			end
			if (!tok_i.hit && hit_now) begin
				tok_d.hit  = 1'b1;
				tok_d.pick = ctl.med ? elem_q : LRQ_DATA_W'(IDX);
			end
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			cnt_q <= '0;
		end else begin
			tok_q <= tok_d;
			cnt_q <= cnt_d;
		end
	end

	assign tok_o = tok_q;
	assign cnt_o = cnt_q;
	assign rl_o  = rl_q;
	assign ll_o  = ll_q;

endmodule

FILE: hw/rtl/list_rank_query_engine_top.sv
// Channel | Dir | Fields                         | Transfer
// cmd     | in  | command, value, rank_basis     | valid & ready
// rsp     | out | answer, status                 | valid & ready
//
// Append, clear, empty-list queries and unknown commands: straight to S_FIN, then the result register.
// Max below, distance and count below: S_SCAN, the token walk down the cell row, then S_FIN.
// Median: S_RANK, a rank sweep over the row, followed by the token walk in S_SCAN, then S_FIN.
// One command is in work at a time; a new command is taken while the result register still waits.
// arst_n clears the element count, the sequencer and the result register.
module list_rank_query_engine_top import lrq_pkg::*; #(
	parameter int MAX_ELEMENTS = LRQ_MAX_ELEMENTS
) (
	input  logic          clk,
	input  logic          arst_n,
	lrq_cmd_if.sink       cmd,
	lrq_rsp_if.source     rsp
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = $clog2(MAX_ELEMENTS);
	localparam logic [CW-1:0] FULL_C    = CW'(MAX_ELEMENTS);
	localparam logic [SW-1:0] LAST_STEP = SW'(MAX_ELEMENTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RANK = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                    state_q;
	logic [SW-1:0]                 step_q;
	logic [CW-1:0]                 count_q;
	logic                          start_q;
	logic [LRQ_CMD_W-1:0]          cmd_q;
	logic signed [LRQ_DATA_W-1:0]  key_q;
	logic [LRQ_TGT_W-1:0]          tgt_q;
	logic signed [LRQ_DATA_W-1:0]  ans_q;
	logic [LRQ_STATUS_W-1:0]       stat_q;
	logic                          ovld_q;
	logic signed [LRQ_DATA_W-1:0]  oans_q;
	logic [LRQ_STATUS_W-1:0]       ostat_q;

	logic      accept;
	logic      is_query;
	logic      rank_last;
	logic      out_free;
	lrq_ctl_t  ctl;

	lrq_tok_t      tok_w [MAX_ELEMENTS+1];
	logic [CW-1:0] cnt_w [MAX_ELEMENTS+1];
	lrq_line_t     rl_w  [MAX_ELEMENTS+1];
	lrq_line_t     ll_w  [MAX_ELEMENTS+1];

	assign cmd.ready = state_q == S_IDLE;
	assign accept    = cmd.valid && cmd.ready;
	assign is_query  = cmd.command inside {CMD_MAX_BELOW, CMD_DISTANCE, CMD_COUNT, CMD_MEDIAN};
	assign rank_last = (state_q == S_RANK) && (step_q == LAST_STEP);
	assign out_free  = !ovld_q || rsp.ready;

	// Broadcast control to the cells
	always_comb begin
		ctl.wr_en   = accept && (cmd.command == CMD_APPEND) && (count_q != FULL_C);
		ctl.load    = accept && (cmd.command == CMD_MEDIAN) && (count_q != '0);
		ctl.rank_en = state_q == S_RANK;
		ctl.med     = cmd_q == CMD_MEDIAN;
		ctl.wr_val  = cmd.value;
		ctl.key     = key_q;
	end

	// Sequencer: take a command, run the rank sweep and token walk as the query needs, post the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
			start_q <= 1'b0;
			cmd_q   <= CMD_APPEND;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd.command;
						step_q <= '0;
						state_q <= S_FIN;
						if (cmd.command == CMD_APPEND) begin
							if (count_q != FULL_C) begin
								count_q <= count_q + 1'b1;
							end
						end else if (cmd.command == CMD_CLEAR) begin
							count_q <= '0;
						end else if (is_query && (count_q != '0)) begin
							if (cmd.command == CMD_MEDIAN) begin
								state_q <= S_RANK;
							end else begin
								state_q <= S_SCAN;
								start_q <= 1'b1;
							end
						end
					end
				end
				S_RANK: begin
					step_q <= step_q + 1'b1;
					if (rank_last) begin
						state_q <= S_SCAN;
						start_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (tok_w[MAX_ELEMENTS].vld) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the query operands and form the answer
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= cmd.value;
			tgt_q  <= cmd.rank_basis[LRQ_BASIS_W-1:1];
			ans_q  <= '0;
			stat_q <= ST_OK;
			if ((cmd.command == CMD_APPEND) && (count_q == FULL_C)) begin
				stat_q <= ST_FULL;
			end else if (is_query && (count_q == '0)) begin
				stat_q <= ST_EMPTY;
			end
		end else if ((state_q == S_SCAN) && tok_w[MAX_ELEMENTS].vld) begin
			case (cmd_q)
				CMD_MAX_BELOW: ans_q <= tok_w[MAX_ELEMENTS].anyb ?
					tok_w[MAX_ELEMENTS].maxb : tok_w[MAX_ELEMENTS].minv;
				CMD_COUNT: ans_q <= LRQ_DATA_W'(cnt_w[MAX_ELEMENTS]);
				default: ans_q <= tok_w[MAX_ELEMENTS].pick;
			endcase
		end
	end

	// Result register toward the sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if ((state_q == S_FIN) && out_free) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			oans_q  <= ans_q;
			ostat_q <= stat_q;
		end
	end

	assign rsp.valid  = ovld_q;
	assign rsp.answer = oans_q;
	assign rsp.status = ostat_q;

	// Chain ends: fresh token at the head, empty slots at the line ends
	assign tok_w[0]           = {start_q, ($bits(lrq_tok_t) - 1)'(0)};
	assign cnt_w[0]           = '0;
	assign rl_w[0]            = '0;
	assign ll_w[MAX_ELEMENTS] = '0;

	// Row of element cells
	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		lrq_cell #(
			.MAX_ELEMENTS(MAX_ELEMENTS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.count(count_q),
			.target(tgt_q),
			.tok_i(tok_w[i]),
			.cnt_i(cnt_w[i]),
			.tok_o(tok_w[i+1]),
			.cnt_o(cnt_w[i+1]),
			.rl_i(rl_w[i]),
			.rl_o(rl_w[i+1]),
			.ll_i(ll_w[i+1]),
			.ll_o(ll_w[i])
		);
	end

endmodule

FILE: dv/lrq_result_checker.sv
`timescale 1ns / 1ps

module lrq_result_checker import lrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lrq_cmd_if   cmd,
	lrq_rsp_if   rsp,
	output int   fail_count,
	output int   awaiting
);

	typedef struct packed {
		logic signed [LRQ_DATA_W-1:0] answer;
		logic [LRQ_STATUS_W-1:0]      status;
	} lrq_result_t;

	// Shadow copy of the element list
	logic signed [LRQ_DATA_W-1:0] shadow [LRQ_MAX_ELEMENTS];
	int unsigned                  depth;

	lrq_result_t owed_q[$];
	lrq_result_t due;
	int          mismatches;

	function automatic int unsigned count_under(input logic signed [LRQ_DATA_W-1:0] v);
		int unsigned n;
		n = 0;
		for (int unsigned i = 0; i < depth; i++)
			if (shadow[i] < v)
				n++;
		return n;
	endfunction

	function automatic logic signed [LRQ_DATA_W-1:0] smallest_held();
		logic signed [LRQ_DATA_W-1:0] m;
		m = shadow[0];
		for (int unsigned i = 1; i < depth; i++)
			if (shadow[i] < m)
				m = shadow[i];
		return m;
	endfunction

	// Fall back to the list minimum when nothing lies below v
	function automatic logic signed [LRQ_DATA_W-1:0] largest_below(
		input logic signed [LRQ_DATA_W-1:0] v
	);
		logic signed [LRQ_DATA_W-1:0] best;
		best = smallest_held();
		for (int unsigned i = 0; i < depth; i++)
			if (best < shadow[i] && shadow[i] < v)
				best = shadow[i];
		return best;
	endfunction

	// Stop at the last index when no element matches
	function automatic int unsigned match_index(input logic signed [LRQ_DATA_W-1:0] v);
		int unsigned i;
		i = 0;
		while (i + 1 < depth && shadow[i] != v)
			i++;
		return i;
	endfunction

	// First element before the last whose rank equals floor(k/2), else the last one
	function automatic logic signed [LRQ_DATA_W-1:0] median_by_rank(
		input logic [LRQ_BASIS_W-1:0] k
	);
		for (int unsigned i = 0; i + 1 < depth; i++)
			if (count_under(shadow[i]) == (k >> 1))
				return shadow[i];
		return shadow[depth-1];
	endfunction

	function automatic lrq_result_t apply_command(
		input logic [LRQ_CMD_W-1:0]         op,
		input logic signed [LRQ_DATA_W-1:0] v,
		input logic [LRQ_BASIS_W-1:0]       k
	);
		lrq_result_t res;
		res.answer = '0;
		res.status = ST_OK;
		case (op)
			CMD_APPEND: begin
				if (depth >= LRQ_MAX_ELEMENTS) begin
					res.status = ST_FULL;
				end else begin
					shadow[depth] = v;
					depth++;
				end
			end
			CMD_CLEAR: begin
				depth = 0;
			end
			CMD_MAX_BELOW, CMD_DISTANCE, CMD_COUNT, CMD_MEDIAN: begin
				if (depth == 0) begin
					res.status = ST_EMPTY;
				end else begin
					case (op)
						CMD_MAX_BELOW: res.answer = largest_below(v);
						CMD_DISTANCE:  res.answer = match_index(v);
						CMD_COUNT:     res.answer = count_under(v);
						default:       res.answer = median_by_rank(k);
					endcase
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Retire result transactions first, then queue the prediction for a new command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth = 0;
			owed_q.delete();
			mismatches = 0;
			awaiting   <= 0;
			fail_count <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected result transaction: answer %0d, status %0d",
						rsp.answer, rsp.status);
					mismatches++;
				end else begin
					due = owed_q.pop_front();
					if (rsp.answer !== due.answer) begin
						$error("answer: expected %0d, got %0d", due.answer, rsp.answer);
						mismatches++;
					end
					if (rsp.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, rsp.status);
						mismatches++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				owed_q.push_back(apply_command(cmd.command, cmd.value, cmd.rank_basis));
			awaiting   <= owed_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: dv/tb_list_rank_query_engine_top.sv
`timescale 1ns / 1ps

module tb_list_rank_query_engine_top import lrq_pkg::*; ();

	// Command codes the block must ignore
	localparam logic [LRQ_CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [LRQ_CMD_W-1:0] CMD_SPARE_B = 3'd7;

	localparam logic signed [LRQ_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [LRQ_DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	localparam int ITEM_TARGET   = 900;
	localparam int GAP_MAX       = 17;
	localparam int HOLD_CYCLES   = 2000;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;

	lrq_cmd_if cmd();
	lrq_rsp_if rsp();

	int fail_count;
	int awaiting;
	int hold_reqs;

	int                           items_sent;
	int unsigned                  gap_next;
	bit                           src_burst;
	logic signed [LRQ_DATA_W-1:0] appended[$];

	list_rank_query_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	lrq_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (fail_count),
		.awaiting   (awaiting)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("FAILURE");
		$finish;
	end

	// Mostly small values so that duplicates and matches are common
	function automatic logic signed [LRQ_DATA_W-1:0] draw_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $signed(32'($urandom_range(0, 40))) - 32'sd20;
		if (r < 65)
			return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
		if (r < 85)
			return $urandom();
		case (r % 4)
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return '0;
			default: return -32'sd1;
		endcase
	endfunction

	// Probe near a stored element half of the time
	function automatic logic signed [LRQ_DATA_W-1:0] draw_probe();
		if (appended.size() > 0 && $urandom_range(0, 1) == 1)
			return appended[$urandom_range(0, appended.size() - 1)]
				+ ($signed(32'($urandom_range(0, 2))) - 32'sd1);
		return draw_value();
	endfunction

	function automatic logic [LRQ_BASIS_W-1:0] draw_basis();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 10'(appended.size());
		if (r < 70)
			return 10'(appended.size() + $urandom_range(0, 2) - 1);
		if (r < 90)
			return 10'($urandom_range(0, 1023));
		case (r % 3)
			0:       return '0;
			1:       return 10'd512;
			default: return 10'h3FF;
		endcase
	endfunction

	function automatic logic [LRQ_CMD_W-1:0] pick_query();
		case ($urandom_range(0, 3))
			0:       return CMD_MAX_BELOW;
			1:       return CMD_DISTANCE;
			2:       return CMD_COUNT;
			default: return CMD_MEDIAN;
		endcase
	endfunction

	// Drive one command transaction; keep valid high when the next one follows at once
	task automatic issue(
		input logic [LRQ_CMD_W-1:0]         op,
		input logic signed [LRQ_DATA_W-1:0] v,
		input logic [LRQ_BASIS_W-1:0]       k
	);
		if (gap_next > 0)
			repeat (gap_next) @(posedge clk);
		cmd.valid      <= 1'b1;
		cmd.command    <= op;
		cmd.value      <= v;
		cmd.rank_basis <= k;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		items_sent++;
		if (op == CMD_APPEND && appended.size() < LRQ_MAX_ELEMENTS)
			appended.push_back(v);
		else if (op == CMD_CLEAR)
			appended.delete();
		gap_next = src_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap_next > 0)
			cmd.valid <= 1'b0;
	endtask

	// Hold the command side until every result has come back
	task automatic halt_and_drain();
		if (gap_next == 0)
			cmd.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		gap_next = 0;
	endtask

	// Fill the list past capacity while the response side holds off
	task automatic fill_to_capacity();
		src_burst = 1'b1;
		hold_reqs <= hold_reqs + 1;
		issue(CMD_CLEAR, draw_value(), draw_basis());
		repeat (LRQ_MAX_ELEMENTS + 2)
			issue(CMD_APPEND, draw_value(), draw_basis());
		src_burst = 1'b0;
		repeat (12)
			issue(pick_query(), draw_probe(), draw_basis());
	endtask

	task automatic mixed_episode();
		int unsigned size;
		int unsigned steps;
		int unsigned r;
		size  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 120);
		steps = 2 * size + $urandom_range(2, 10);
		if ($urandom_range(0, 9) != 0)
			issue(CMD_CLEAR, draw_value(), draw_basis());
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (r < 45 && appended.size() < size)
				issue(CMD_APPEND, draw_value(), draw_basis());
			else if (r < 93)
				issue(pick_query(), draw_probe(), draw_basis());
			else if (r < 97)
				issue(r[0] ? CMD_SPARE_A : CMD_SPARE_B, draw_value(), draw_basis());
			else if (r < 99)
				issue(CMD_CLEAR, draw_value(), draw_basis());
			else
				issue(CMD_APPEND, draw_value(), draw_basis());
		end
	endtask

	// Response side: random stalls, burst stretches, and one long hold-off on request
	initial begin : sink_side
		int unsigned stall;
		int          holds_served;
		bit          sink_burst;
		holds_served = 0;
		sink_burst   = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_reqs != holds_served) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end
			if ($urandom_range(0, 39) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	initial begin : source_side
		int episode;
		arst_n         <= 1'b0;
		hold_reqs      <= 0;
		cmd.valid      <= 1'b0;
		cmd.command    <= CMD_APPEND;
		cmd.value      <= '0;
		cmd.rank_basis <= '0;
		items_sent = 0;
		src_burst  = 1'b0;
		gap_next   = 0;
		episode    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries on an empty list, then the unused command codes
		issue(CMD_MAX_BELOW, '0, '0);
		issue(CMD_DISTANCE, '0, '0);
		issue(CMD_COUNT, '0, '0);
		issue(CMD_MEDIAN, '0, '0);
		issue(CMD_SPARE_A, VAL_MAX, 10'h3FF);
		issue(CMD_SPARE_B, VAL_MIN, '0);

		// Extreme values with a duplicate
		issue(CMD_APPEND, VAL_MIN, '0);
		issue(CMD_APPEND, VAL_MAX, 10'h3FF);
		issue(CMD_APPEND, '0, '0);
		issue(CMD_APPEND, -32'sd1, '0);
		issue(CMD_APPEND, 32'sd5, '0);
		issue(CMD_APPEND, 32'sd5, '0);

		// Nothing below the minimum, match and no match, rank edges
		issue(CMD_MAX_BELOW, VAL_MIN, '0);
		issue(CMD_MAX_BELOW, VAL_MAX, '0);
		issue(CMD_DISTANCE, 32'sd5, '0);
		issue(CMD_DISTANCE, 32'sd12345, '0);
		issue(CMD_COUNT, VAL_MAX, '0);
		issue(CMD_COUNT, VAL_MIN, '0);
		issue(CMD_MEDIAN, '0, 10'd6);
		issue(CMD_MEDIAN, '0, 10'h3FF);
		issue(CMD_MEDIAN, '0, '0);

		// Clear keeps the store but empties the list
		issue(CMD_CLEAR, '0, '0);
		issue(CMD_COUNT, '0, '0);
		halt_and_drain();

		// Random episodes; the second one runs the list full under back-pressure
		while (items_sent < ITEM_TARGET) begin
			src_burst = ($urandom_range(0, 3) == 0);
			if (episode == 1)
				fill_to_capacity();
			else
				mixed_episode();
			if (episode == 1 || $urandom_range(0, 4) == 0)
				halt_and_drain();
			episode++;
		end

		halt_and_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/lrq_pkg.sv
hw/rtl/lrq_cmd_if.sv
hw/rtl/lrq_rsp_if.sv
hw/rtl/lrq_cell.sv
hw/rtl/list_rank_query_engine_top.sv
dv/lrq_result_checker.sv
dv/tb_list_rank_query_engine_top.sv
